[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hex grid binning checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define HGCB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hgcb assertion failed");

// Clocked assertion that is also checked while reset is high.
`define HGCB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hgcb assertion failed");

`endif

[hw/rtl/hgcb_pkg.sv]
// ----------------------------------------------------------------------------
// hgcb_pkg
// Types, constants and helpers of the hex grid cell binning core.
// ----------------------------------------------------------------------------
package hgcb_pkg;

  // Default number of fraction bits of positions and the reciprocal.
  localparam int FRAC_BITS_DEF = 16;

  // floor(sqrt(3) * 2^30), also the nearest value.
  localparam logic [31:0] SQRT3_Q30 = 32'd1859775393;

  // Reset value of the edge reciprocal register (1.0 at 16 fraction bits).
  localparam logic [31:0] EDGE_RECIP_RST = 32'd65536;

  // Width of the exact cube-coordinate numerators.
  localparam int NUM_W = 98;

  // Width of one stream beat.
  localparam int STREAM_W = 64;

  // Exact division by three: number of shift-and-add doubling steps.
  localparam int DIV_STEPS = 5;

  // Residue-mod-three tree over base-four digits.
  localparam int MOD3_LEAVES = 32;
  localparam int MOD3_LEVELS = 5;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  localparam int NUM_LANES = 3;

  typedef enum logic [1:0] {
    LANE_Q = 2'd0,
    LANE_R = 2'd1,
    LANE_S = 2'd2
  } lane_t;

  // Sum of two residues modulo three; a raw base-four digit is reduced by
  // adding zero.
  function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = 3'(a) + 3'(b);
    return (s >= 3'd3) ? 2'(s - 3'd3) : 2'(s);
  endfunction

endpackage

[hw/rtl/hex_grid_cell_binning_core.sv]
// ----------------------------------------------------------------------------
// hex_grid_cell_binning_core
// Maps a planar fixed-point point to the axial index of its pointy-top hexagon.
// ----------------------------------------------------------------------------
//
//  Channel     Direction  Payload (lowest bits first)
//  s_*         in         pos_x[31:0], pos_y[31:0]
//  m_*         out        cell_q[31:0], cell_r[31:0]
//  edge_recip  config     edge_recip[31:0], written when edge_recip_we is high
//
//  One item is taken per clock cycle while s_tready is high. A result
//  reaches m_tvalid through the NSTG pipeline stages and the output register.
//  Reset (rst, synchronous) empties the pipeline, the output register and the
//  skid register, and loads the reset reciprocal.
//  When m_tready is held low the result parks in the output register and one
//  more result in the skid register; s_tready then falls and the whole
//  pipeline holds, so nothing is lost or repeated.
//
// The numerators are exact: Nq = (sqrt3*x - 2^30*y)*e, Nr = 2^31*y*e and
// Ns = -Nq - Nr over the denominator 3*2^K with K = 30 + 2*FRAC_BITS. Each
// is rounded half away from zero by adding 1.5*2^K to its magnitude, taking
// the top bits t and dividing t by three. The division is exact after the
// residue of t modulo three is removed, so it becomes a multiplication by
// the inverse of three modulo 2^TW, done as a chain of shift-and-add steps.
// The rounding error depends only on that residue and the low K bits, which
// avoids multiplying the rounded value back up.

module hex_grid_cell_binning_core
  import hgcb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration register.
  input  logic                edge_recip_we,
  input  logic [31:0]         edge_recip_wdata,
  // Input stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [STREAM_W-1:0] s_tdata,   // pos_x[31:0], pos_y[63:32]
  // Output stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [STREAM_W-1:0] m_tdata    // cell_q[31:0], cell_r[63:32]
);

  // Scale of the denominator and the widths that follow from it.
  localparam int K    = 30 + 2 * FRAC_BITS;
  localparam int TW   = NUM_W - K;          // top bits after the rounding add
  localparam int EW   = K + 1;              // rounding error
  localparam int VW   = TW + 1;             // signed rounded coordinate
  localparam int BW   = TW + 2;             // rebuilt coordinate
  localparam int RW   = (BW > 33) ? BW : 33;
  localparam int NSTG = 9 + DIV_STEPS;      // pipeline register stages

  localparam logic [NUM_W-1:0] ROUND_ADD = NUM_W'(3) << (K - 1);
  localparam logic [EW-1:0]    ERR_HALF  = EW'(1) << (K - 1);
  localparam logic [EW-1:0]    ERR_3HALF = EW'(3) << (K - 1);

  // --------------------------------------------------------------------------
  // Configuration and flow control
  // --------------------------------------------------------------------------
  logic [31:0]     edge_recip;
  logic [NSTG:1]   vld;
  logic            skid_vld;
  logic [STREAM_W-1:0] skid_data;
  logic            en;
  logic            arrive;

  // The pipeline moves as one; it holds only while the skid register is full.
  assign en       = !skid_vld;
  assign s_tready = en;
  assign arrive   = en && vld[NSTG];

  // --------------------------------------------------------------------------
  // Stage 1: the two products of the inputs.
  // --------------------------------------------------------------------------
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [63:0] px_c;
  logic signed [64:0] ye_c;
  logic signed [63:0] px1;
  logic signed [64:0] ye1;
  logic [31:0]        e1;

  assign in_x = s_tdata[31:0];
  assign in_y = s_tdata[63:32];
  assign px_c = in_x * $signed(SQRT3_Q30);
  assign ye_c = in_y * $signed({1'b0, edge_recip});

  // --------------------------------------------------------------------------
  // Stage 2: sqrt3*x times the reciprocal, split into two partial products.
  // --------------------------------------------------------------------------
  logic [63:0]        pl_c;
  logic signed [63:0] ph_c;
  logic [63:0]        pl2;
  logic signed [63:0] ph2;
  logic signed [64:0] ye2;

  assign pl_c = px1[31:0] * e1;
  assign ph_c = $signed(px1[63:32]) * $signed({1'b0, e1});

  // --------------------------------------------------------------------------
  // Stage 3: join the partial products.
  // --------------------------------------------------------------------------
  logic signed [NUM_W-1:0] xe_c;
  logic signed [NUM_W-1:0] xe3;
  logic signed [64:0]      ye3;

  assign xe_c = (NUM_W'(ph2) <<< 32) + $signed(NUM_W'(pl2));

  // --------------------------------------------------------------------------
  // Stage 4: numerators of q and r, and q + r for the s lane.
  // --------------------------------------------------------------------------
  logic signed [NUM_W-1:0] yw;
  logic [NUM_W-1:0]        num_c [NUM_LANES];
  logic [NUM_W-1:0]        a4    [NUM_LANES];

  always_comb begin
    yw             = NUM_W'(ye3);
    num_c[LANE_Q]  = xe3 - (yw <<< 30);
    num_c[LANE_R]  = yw <<< 31;
    // Ns = -(q + r): its magnitude is that of the sum, its sign the opposite.
    num_c[LANE_S]  = xe3 + (yw <<< 30);
  end

  // --------------------------------------------------------------------------
  // Stage 5: magnitude plus 1.5 * 2^K in one add.
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0] h_c   [NUM_LANES];
  logic [TW-1:0]    t5    [NUM_LANES];
  logic [K-1:0]     l5    [NUM_LANES];
  logic             neg5  [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      h_c[l] = (a4[l][NUM_W-1] ? ~a4[l] : a4[l]) + ROUND_ADD
               + NUM_W'(a4[l][NUM_W-1]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: residue of t modulo three, rounding error, t less the residue.
  // --------------------------------------------------------------------------
  function automatic logic [1:0] mod3_of(input logic [TW-1:0] v);
    logic [2*MOD3_LEAVES-1:0] pad;
    logic [1:0]               res [MOD3_LEAVES];
    pad = (2 * MOD3_LEAVES)'(v);
    for (int i = 0; i < MOD3_LEAVES; i++) begin
      res[i] = add_mod3(pad[2*i +: 2], 2'd0);
    end
    for (int lv = 0; lv < MOD3_LEVELS; lv++) begin
      for (int j = 0; j < MOD3_LEAVES / 2; j++) begin
        res[j] = add_mod3(res[2*j], res[2*j+1]);
      end
    end
    return res[0];
  endfunction

  logic [1:0]    rem_c [NUM_LANES];
  logic [EW-1:0] err_c [NUM_LANES];
  logic [EW-1:0] lx    [NUM_LANES];
  logic [EW-1:0] e6    [NUM_LANES];
  logic [TW-1:0] tm6   [NUM_LANES];
  logic          neg6  [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      rem_c[l] = mod3_of(t5[l]);
      lx[l]    = {1'b0, l5[l]};
      if (rem_c[l] == 2'd0) begin
        err_c[l] = ERR_3HALF - lx[l];
      end else if (rem_c[l] == 2'd1) begin
        err_c[l] = l5[l][K-1] ? (lx[l] - ERR_HALF) : (ERR_HALF - lx[l]);
      end else begin
        err_c[l] = lx[l] + ERR_HALF;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 7 to 6 + DIV_STEPS: error compare, alongside t * 0x...5555 by doubling.
  // --------------------------------------------------------------------------
  logic [TW-1:0] acc_d [DIV_STEPS][NUM_LANES];
  logic [TW-1:0] tm_d  [DIV_STEPS][NUM_LANES];
  logic          neg_d [DIV_STEPS][NUM_LANES];
  logic          gq_d  [DIV_STEPS];
  logic          gr_d  [DIV_STEPS];

  // --------------------------------------------------------------------------
  // Final stages: quotient, sign, rebuild of the worst component.
  // --------------------------------------------------------------------------
  logic [TW-1:0]        n12   [NUM_LANES];
  logic                 neg12 [NUM_LANES];
  logic                 gq12;
  logic                 gr12;
  logic signed [VW-1:0] v13   [NUM_LANES];
  logic                 gq13;
  logic                 gr13;
  logic signed [BW-1:0] q14;
  logic signed [BW-1:0] r14;
  logic signed [BW-1:0] bq;
  logic signed [BW-1:0] br;
  logic signed [BW-1:0] bs;

  assign bq = BW'(v13[LANE_Q]);
  assign br = BW'(v13[LANE_R]);
  assign bs = BW'(v13[LANE_S]);

  function automatic logic [31:0] sat32(input logic signed [BW-1:0] v);
    logic signed [RW-1:0] ext;
    ext = RW'(v);
    if ((&ext[RW-1:31]) || !(|ext[RW-1:31])) begin
      return ext[31:0];
    end
    return ext[RW-1] ? SAT_MIN : SAT_MAX;
  endfunction

  logic [STREAM_W-1:0] res_c;
  assign res_c = {sat32(r14), sat32(q14)};

  // --------------------------------------------------------------------------
  // Pipeline registers (payload, no reset).
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= px_c;
      ye1 <= ye_c;
      e1  <= edge_recip;

      pl2 <= pl_c;
      ph2 <= ph_c;
      ye2 <= ye1;

      xe3 <= xe_c;
      ye3 <= ye2;

      a4 <= num_c;

      for (int l = 0; l < NUM_LANES; l++) begin
        t5[l]   <= h_c[l][NUM_W-1:K];
        l5[l]   <= h_c[l][K-1:0];
        neg5[l] <= a4[l][NUM_W-1] ^ (l == int'(LANE_S));

        e6[l]   <= err_c[l];
        tm6[l]  <= t5[l] - TW'(rem_c[l]);
        neg6[l] <= neg5[l];

        acc_d[0][l] <= tm6[l] + (tm6[l] << 2);
        tm_d[0][l]  <= tm6[l];
        neg_d[0][l] <= neg6[l];
        for (int j = 1; j < DIV_STEPS; j++) begin
          acc_d[j][l] <= acc_d[j-1][l] + (acc_d[j-1][l] << (2 << j));
          tm_d[j][l]  <= tm_d[j-1][l];
          neg_d[j][l] <= neg_d[j-1][l];
        end

        // tm * (1 + 2 * 0x...5555) is tm / 3 modulo 2^TW.
        n12[l]   <= tm_d[DIV_STEPS-1][l] + (acc_d[DIV_STEPS-1][l] << 1);
        neg12[l] <= neg_d[DIV_STEPS-1][l];

        v13[l] <= neg12[l] ? -$signed({1'b0, n12[l]}) : $signed({1'b0, n12[l]});
      end

      // q is rebuilt only when its error beats both others; r when it beats s and q is not rebuilt.
      gq_d[0] <= (e6[LANE_Q] > e6[LANE_R]) && (e6[LANE_Q] > e6[LANE_S]);
      gr_d[0] <= e6[LANE_R] > e6[LANE_S];
      for (int j = 1; j < DIV_STEPS; j++) begin
        gq_d[j] <= gq_d[j-1];
        gr_d[j] <= gr_d[j-1];
      end
      gq12 <= gq_d[DIV_STEPS-1];
      gr12 <= gr_d[DIV_STEPS-1];
      gq13 <= gq12;
      gr13 <= gr12;

      q14 <= gq13 ? (-br - bs) : bq;
      r14 <= (!gq13 && gr13) ? (-bq - bs) : br;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers: configuration, valid bits, output and skid.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_recip <= EDGE_RECIP_RST;
      vld        <= '0;
      m_tvalid   <= 1'b0;
      skid_vld   <= 1'b0;
    end else begin
      if (edge_recip_we) begin
        edge_recip <= edge_recip_wdata;
      end
      if (en) begin
        vld <= {vld[NSTG-1:1], s_tvalid};
      end
      if (!m_tvalid || m_tready) begin
        if (skid_vld) begin
          m_tvalid <= 1'b1;
          skid_vld <= 1'b0;
        end else begin
          m_tvalid <= arrive;
        end
      end else if (arrive) begin
        skid_vld <= 1'b1;
      end
    end
  end

  // Output and skid payload follow the same choices as their valid bits.
  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= skid_vld ? skid_data : res_c;
    end else if (arrive) begin
      skid_data <= res_c;
    end
  end

endmodule

[hw/rtl/hgcb_checker.sv]
// ----------------------------------------------------------------------------
// hgcb_checker
// Port-level assertions for the hex grid cell binning core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hgcb_checker
  import hgcb_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [STREAM_W-1:0] m_tdata
);

  // A stalled result stays offered and unchanged.
  `HGCB_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // Reset leaves no result offered and the input open.
  `HGCB_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid && s_tready)

  // The input only closes while a result is waiting at the output.
  `HGCB_ASSERT(a_backpressure_cause, clk, rst, !s_tready |-> m_tvalid)

  // Once closed, the input stays closed until the output accepts a result.
  `HGCB_ASSERT(a_backpressure_hold, clk, rst, !s_tready && !m_tready |=> !s_tready)

  // The input being closed with a valid item waiting must not clear the output.
  `HGCB_ASSERT(a_wait_keeps_out, clk, rst, s_tvalid && !s_tready |-> m_tvalid)

endmodule

bind hex_grid_cell_binning_core hgcb_checker u_hgcb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
